/* hdl/bfsp_pkg.sv */
// Shared types and constants for the shortest-path engine.
package bfsp_pkg;

  localparam int unsigned VTX_W      = 5;
  localparam int unsigned DIST_W     = 32;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned VCNT_W     = 6;
  localparam int unsigned ECNT_W     = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_COUNT   = 2'd1;

  localparam logic [VCNT_W-1:0] VCNT_RESET = 6'd5;
  localparam logic [ECNT_W-1:0] ECNT_RESET = 7'd0;

  localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;

  // One write to the distance store; also registered for forwarding.
  typedef struct packed {
    logic                     we;
    logic [VTX_W-1:0]         vtx;
    logic signed [DIST_W-1:0] dval;
  } dist_wr_t;

endpackage

/* hdl/bfsp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module bfsp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/bfsp_relax.sv */
// Relaxation step of one edge: forwarding, saturating add, compare, write-back.
module bfsp_relax #(
  parameter int unsigned MAX_VERTICES = 32,
  parameter int unsigned WEIGHT_BITS  = 16,
  localparam int unsigned NVW = $clog2(MAX_VERTICES + 1)
) (
  input  logic                                valid_i,
  input  logic [bfsp_pkg::VTX_W-1:0]          from_i,
  input  logic [bfsp_pkg::VTX_W-1:0]          to_i,
  input  logic signed [WEIGHT_BITS-1:0]       weight_i,
  input  logic [NVW-1:0]                      nv_i,
  input  logic [MAX_VERTICES-1:0]             reached_i,
  input  logic signed [bfsp_pkg::DIST_W-1:0]  dist_from_i,
  input  logic signed [bfsp_pkg::DIST_W-1:0]  dist_to_i,
  input  bfsp_pkg::dist_wr_t                  fwd_i,
  output bfsp_pkg::dist_wr_t                  wr_o
);

  import bfsp_pkg::*;

  localparam int unsigned VAW   = $clog2(MAX_VERTICES);
  localparam int unsigned SUM_W = DIST_W + 1;

  logic signed [DIST_W-1:0] du;
  logic signed [DIST_W-1:0] dv;
  logic signed [DIST_W-1:0] cand;
  logic signed [SUM_W-1:0]  sum;
  logic                     reach_u;
  logic                     reach_v;
  logic                     skip;
  logic                     better;

  // The write issued in the previous cycle is not yet visible in the RAM read data.
  assign du = (fwd_i.we && (fwd_i.vtx == from_i)) ? fwd_i.dval : dist_from_i;
  assign dv = (fwd_i.we && (fwd_i.vtx == to_i))   ? fwd_i.dval : dist_to_i;

  assign sum = SUM_W'(du) + SUM_W'(weight_i);

  always_comb begin
    if (sum[SUM_W-1] != sum[SUM_W-2]) begin
      cand = sum[SUM_W-1] ? DIST_MIN : DIST_MAX;
    end else begin
      cand = sum[DIST_W-1:0];
    end
  end

  assign reach_u = reached_i[VAW'(from_i)];
  assign reach_v = reached_i[VAW'(to_i)];

  // Out-of-range endpoints and unreached tails are skipped.
  assign skip   = (from_i >= nv_i) || (to_i >= nv_i) || !reach_u;
  assign better = !reach_v || (cand < dv);

  assign wr_o.we   = valid_i && !skip && better;
  assign wr_o.vtx  = to_i;
  assign wr_o.dval = cand;

endmodule

/* hdl/bellman_ford_shortest_paths.sv */
// Load item: no result. Run item: an init state, then relaxation (no edges issued when nv
// is 1 or ne is 0), one edge per cycle through edge read, distance read and relax/write
// stages. Readout then steps through read, capture and hold states per vertex, waiting
// in hold while the output is stalled. nv = min(vertex_count, MAX_VERTICES), ne likewise.
// Reset (async, active low) clears control and reached marks and reloads the counts; the
// payload registers, edge table and distance RAMs are not cleared.
module bellman_ford_shortest_paths #(
  parameter int unsigned MAX_VERTICES = 32,
  parameter int unsigned MAX_EDGES    = 64,
  parameter int unsigned WEIGHT_BITS  = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 operation_i,
  input  logic [bfsp_pkg::SLOT_W-1:0]          edge_slot_i,
  input  logic [bfsp_pkg::VTX_W-1:0]           edge_from_i,
  input  logic [bfsp_pkg::VTX_W-1:0]           edge_to_i,
  input  logic signed [15:0]                   edge_weight_i,
  input  logic [bfsp_pkg::VTX_W-1:0]           source_vertex_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [bfsp_pkg::VTX_W-1:0]           vertex_index_o,
  output logic signed [bfsp_pkg::DIST_W-1:0]   distance_o,
  output logic                                 reachable_o,
  output logic                                 last_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [bfsp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bfsp_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  import bfsp_pkg::*;

  localparam int unsigned VAW    = $clog2(MAX_VERTICES);
  localparam int unsigned NVW    = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EAW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned EW     = $clog2(MAX_EDGES + 1);
  localparam int unsigned EDGE_W = 2 * VTX_W + WEIGHT_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_RUN  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CAP  = 3'd4;
  localparam logic [2:0] S_HOLD = 3'd5;

  logic [2:0]               state_q, state_d;
  logic [VCNT_W-1:0]        vcount_q, vcount_d;
  logic [ECNT_W-1:0]        ecount_q, ecount_d;
  logic [VTX_W-1:0]         src_q, src_d;
  logic [EW-1:0]            slot_q, slot_d;
  logic [NVW-1:0]           pass_q, pass_d;
  logic                     issuing_q, issuing_d;
  logic                     s1v_q, s2v_q;
  logic [VTX_W-1:0]         s2_from_q, s2_to_q;
  logic signed [WEIGHT_BITS-1:0] s2_weight_q;
  logic [MAX_VERTICES-1:0]  reached_q, reached_d;
  dist_wr_t                 fwd_q;
  logic [NVW-1:0]           k_q, k_d;
  logic                     out_valid_q, out_valid_d;
  logic                     out_load;
  logic [VTX_W-1:0]         out_vtx_q;
  logic signed [DIST_W-1:0] out_dist_q;
  logic                     out_reach_q;
  logic                     out_last_q;

  logic [NVW-1:0]           nv;
  logic [EW-1:0]            ne;
  logic                     in_acc;
  logic                     out_acc;
  logic                     cfg_acc;

  logic                     edge_we;
  logic [EDGE_W-1:0]        edge_wdata;
  logic [EDGE_W-1:0]        edge_rdata;
  logic [WEIGHT_BITS-1:0]   weight_in;
  logic [VTX_W-1:0]         s1_from;
  logic [VTX_W-1:0]         s1_to;

  logic [VAW-1:0]           dist_raddr_a;
  logic signed [DIST_W-1:0] dist_rdata_a;
  logic signed [DIST_W-1:0] dist_rdata_b;
  dist_wr_t                 init_wr;
  dist_wr_t                 relax_wr;
  dist_wr_t                 dist_wr;

  assign nv = (vcount_q > MAX_VERTICES) ? NVW'(MAX_VERTICES) : NVW'(vcount_q);
  assign ne = (ecount_q > MAX_EDGES)    ? EW'(MAX_EDGES)     : EW'(ecount_q);

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_q && out_ready_i;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  // Edge table
  assign weight_in  = WEIGHT_BITS'($unsigned(edge_weight_i));
  assign edge_we    = in_acc && (operation_i == OP_LOAD) && (edge_slot_i < MAX_EDGES);
  assign edge_wdata = {edge_from_i, edge_to_i, weight_in};

  bfsp_ram #(
    .WIDTH (EDGE_W),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (EAW'(edge_slot_i)),
    .wdata_i (edge_wdata),
    .raddr_i (slot_q[EAW-1:0]),
    .rdata_o (edge_rdata)
  );

  assign s1_from = edge_rdata[EDGE_W-1 -: VTX_W];
  assign s1_to   = edge_rdata[WEIGHT_BITS +: VTX_W];

  // Distance store: two mirrored copies give a tail and a head read per cycle.
  assign init_wr.we   = (src_q < nv);
  assign init_wr.vtx  = src_q;
  assign init_wr.dval = '0;
  assign dist_wr      = (state_q == S_INIT) ? init_wr : relax_wr;
  assign dist_raddr_a = (state_q == S_RD) ? VAW'(k_q) : VAW'(s1_from);

  bfsp_ram #(
    .WIDTH (DIST_W),
    .DEPTH (MAX_VERTICES)
  ) u_dist_ram_a (
    .clk_i   (clk_i),
    .we_i    (dist_wr.we),
    .waddr_i (VAW'(dist_wr.vtx)),
    .wdata_i (dist_wr.dval),
    .raddr_i (dist_raddr_a),
    .rdata_o (dist_rdata_a)
  );

  bfsp_ram #(
    .WIDTH (DIST_W),
    .DEPTH (MAX_VERTICES)
  ) u_dist_ram_b (
    .clk_i   (clk_i),
    .we_i    (dist_wr.we),
    .waddr_i (VAW'(dist_wr.vtx)),
    .wdata_i (dist_wr.dval),
    .raddr_i (VAW'(s1_to)),
    .rdata_o (dist_rdata_b)
  );

  bfsp_relax #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_relax (
    .valid_i     (s2v_q),
    .from_i      (s2_from_q),
    .to_i        (s2_to_q),
    .weight_i    (s2_weight_q),
    .nv_i        (nv),
    .reached_i   (reached_q),
    .dist_from_i (dist_rdata_a),
    .dist_to_i   (dist_rdata_b),
    .fwd_i       (fwd_q),
    .wr_o        (relax_wr)
  );

  always_comb begin
    state_d     = state_q;
    vcount_d    = vcount_q;
    ecount_d    = ecount_q;
    src_d       = src_q;
    slot_d      = slot_q;
    pass_d      = pass_q;
    issuing_d   = issuing_q;
    reached_d   = reached_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    out_load    = 1'b0;

    if (cfg_acc) begin
      unique case (cfg_index_i)
        CFG_VERTEX_COUNT: vcount_d = cfg_data_i[VCNT_W-1:0];
        CFG_EDGE_COUNT:   ecount_d = cfg_data_i[ECNT_W-1:0];
        default: ;
      endcase
    end

    if (out_acc) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (operation_i == OP_RUN) && (nv != '0)) begin
          src_d   = source_vertex_i;
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        reached_d = '0;
        if (init_wr.we) begin
          reached_d[VAW'(src_q)] = 1'b1;
        end
        slot_d    = '0;
        pass_d    = '0;
        issuing_d = (nv > NVW'(1)) && (ne != '0);
        state_d   = S_RUN;
      end
      S_RUN: begin
        if (relax_wr.we) begin
          reached_d[VAW'(relax_wr.vtx)] = 1'b1;
        end
        if (issuing_q) begin
          if ((slot_q + 1'b1) == ne) begin
            slot_d = '0;
            if ((pass_q + 2'd2) == nv) begin
              issuing_d = 1'b0;
            end else begin
              pass_d = pass_q + 1'b1;
            end
          end else begin
            slot_d = slot_q + 1'b1;
          end
        end else if (!s1v_q && !s2v_q) begin
          k_d     = '0;
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_CAP;
      end
      S_CAP: begin
        out_load    = 1'b1;
        out_valid_d = 1'b1;
        state_d     = S_HOLD;
      end
      S_HOLD: begin
        if (out_acc) begin
          if ((k_q + 1'b1) == nv) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vcount_q    <= VCNT_RESET;
      ecount_q    <= ECNT_RESET;
      src_q       <= '0;
      slot_q      <= '0;
      pass_q      <= '0;
      issuing_q   <= 1'b0;
      s1v_q       <= 1'b0;
      s2v_q       <= 1'b0;
      reached_q   <= '0;
      fwd_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vcount_q    <= vcount_d;
      ecount_q    <= ecount_d;
      src_q       <= src_d;
      slot_q      <= slot_d;
      pass_q      <= pass_d;
      issuing_q   <= issuing_d;
      s1v_q       <= (state_q == S_RUN) && issuing_q;
      s2v_q       <= s1v_q;
      reached_q   <= reached_d;
      fwd_q       <= dist_wr;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    s2_from_q   <= s1_from;
    s2_to_q     <= s1_to;
    s2_weight_q <= edge_rdata[WEIGHT_BITS-1:0];
    if (out_load) begin
      out_vtx_q   <= VTX_W'(k_q);
      out_reach_q <= reached_q[VAW'(k_q)];
      out_dist_q  <= reached_q[VAW'(k_q)] ? dist_rdata_a : '0;
      out_last_q  <= ((k_q + 1'b1) == nv);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign vertex_index_o = out_vtx_q;
  assign distance_o     = out_dist_q;
  assign reachable_o    = out_reach_q;
  assign last_o         = out_last_q;

  a_out_only_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == S_HOLD))
    else $error("result beat pending outside readout hold");

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!s1v_q && !s2v_q && !issuing_q))
    else $error("relax pipeline busy while idle");

  a_relax_wr_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    relax_wr.we |-> (state_q == S_RUN))
    else $error("distance write-back outside relaxation");

  a_pipe_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1v_q |=> s2v_q)
    else $error("edge lost between read and relax stages");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_o) |=> (state_q == S_IDLE))
    else $error("run did not end after last beat");

endmodule
